### rtl/core/kert_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kert_pkg
// Shared types, constants and the key level step for the keypad tracker.
// ----------------------------------------------------------------------------
package kert_pkg;

   localparam int NUM_KEYS_DEF  = 25;
   localparam int FIXED_KEY_DEF = 19;
   localparam int MASK_W        = 25;
   localparam int KEY_W         = 5;
   localparam int LVL_W         = 2;

   typedef enum logic [LVL_W-1:0] {
      LVL_LOW  = 2'd0,
      LVL_RISE = 2'd1,
      LVL_HIGH = 2'd2,
      LVL_FALL = 2'd3
   } lvl_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_UPD,
      ST_ORD,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [MASK_W-1:0] reported_mask;
      logic [MASK_W-1:0] level_mask;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_index;
      lvl_type          key_state;
      logic             last_event;
   } rsp_type;

   // New level of a reported key. Result equals cur for a settled key.
   function automatic lvl_type lvl_next(lvl_type cur, logic level);
      logic    prev;
      lvl_type nxt;
      prev = (cur == LVL_RISE) || (cur == LVL_HIGH);
      nxt  = cur;
      if (prev != level) begin
         nxt = level ? LVL_RISE : LVL_FALL;
      end else if (cur == LVL_RISE) begin
         nxt = LVL_HIGH;
      end else if (cur == LVL_FALL) begin
         nxt = LVL_LOW;
      end
      return nxt;
   endfunction

endpackage

### rtl/core/kert_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kert_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kert_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/kert_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kert_seq
// Sequencer: walks the level memory and the rank-order memory for one scan.
// ----------------------------------------------------------------------------
module kert_seq #(
   parameter int NUM_KEYS  = kert_pkg::NUM_KEYS_DEF,
   parameter int FIXED_KEY = kert_pkg::FIXED_KEY_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        enable,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  kert_pkg::req_type                           req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output kert_pkg::rsp_type                           rsp_data,
   // level memory, indexed by key
   output logic [$clog2(NUM_KEYS)-1:0]                 a_raddr,
   input  logic [kert_pkg::LVL_W-1:0]                  a_rdata,
   output logic                                        a_we,
   output logic [$clog2(NUM_KEYS)-1:0]                 a_waddr,
   output logic [kert_pkg::LVL_W-1:0]                  a_wdata,
   // order memory, {bank, rank} -> {pending, level, key}
   output logic [$clog2(NUM_KEYS):0]                   b_raddr,
   input  logic [kert_pkg::LVL_W+$clog2(NUM_KEYS):0]   b_rdata,
   output logic                                        b_we,
   output logic [$clog2(NUM_KEYS):0]                   b_waddr,
   output logic [kert_pkg::LVL_W+$clog2(NUM_KEYS):0]   b_wdata
);

   localparam int KW    = $clog2(NUM_KEYS);
   localparam int CW    = $clog2(NUM_KEYS + 1);
   localparam int EXT_W = (NUM_KEYS > kert_pkg::MASK_W) ? NUM_KEYS : kert_pkg::MASK_W;
   localparam bit HID_ON = (FIXED_KEY < NUM_KEYS);
   localparam logic [KW-1:0] HID_KEY   = KW'(FIXED_KEY);
   localparam logic [KW-1:0] LAST_RANK = KW'(NUM_KEYS - 1);
   localparam logic [NUM_KEYS-1:0] HID_MASK =
      HID_ON ? (NUM_KEYS'(1) << FIXED_KEY) : '0;
   localparam logic [CW-1:0] N_CNT    = CW'(NUM_KEYS);
   localparam logic [CW-1:0] CAP      = CW'(NUM_KEYS - 1);
   localparam logic [CW-1:0] FILL_END = HID_ON ? CW'(NUM_KEYS - 1) : CW'(NUM_KEYS);

   // power-up order: keys ascending, hidden key moved to the last rank
   function automatic logic [KW-1:0] reset_key(logic [KW-1:0] r);
      logic [KW-1:0] k;
      k = r;
      if (HID_ON) begin
         if (r == LAST_RANK) begin
            k = HID_KEY;
         end else if (r >= HID_KEY) begin
            k = KW'(r + 1'b1);
         end
      end
      return k;
   endfunction

   kert_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic                p_vld_ff, p_vld_in;
   logic [KW-1:0]       p_idx_ff, p_idx_in;
   logic [CW-1:0]       wptr_ff, wptr_in;
   logic [CW-1:0]       pcnt_ff, pcnt_in;
   logic [CW-1:0]       ecnt_ff, ecnt_in;
   logic [NUM_KEYS-1:0] moved_ff, moved_in;
   logic [NUM_KEYS-1:0] rep_ff, rep_in;
   logic [NUM_KEYS-1:0] lev_ff, lev_in;
   logic                bank_ff, bank_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kert_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [EXT_W-1:0]    rep_ext, lev_ext;
   logic [NUM_KEYS-1:0] rep_scan, lev_scan;
   logic                e_pend;
   kert_pkg::lvl_type   e_lvl;
   logic [KW-1:0]       e_key;
   logic [CW-1:0]       lim;
   logic [CW-1:0]       ecnt_nxt;
   logic                out_free, emit_want, emit_stall, emit_end, scan_end;
   logic                rsp_load, pn;
   kert_pkg::lvl_type   cur_lvl, new_lvl;

   assign rep_ext  = EXT_W'(req_data.reported_mask);
   assign lev_ext  = EXT_W'(req_data.level_mask);
   assign rep_scan = rep_ext[NUM_KEYS-1:0] & ~HID_MASK;
   assign lev_scan = lev_ext[NUM_KEYS-1:0];

   assign e_pend = b_rdata[KW+kert_pkg::LVL_W];
   assign e_lvl  = kert_pkg::lvl_type'(b_rdata[KW +: kert_pkg::LVL_W]);
   assign e_key  = b_rdata[KW-1:0];

   assign cur_lvl = kert_pkg::lvl_type'(a_rdata);
   assign new_lvl = kert_pkg::lvl_next(cur_lvl, lev_ff[p_idx_ff]);

   assign lim        = (pcnt_ff > CAP) ? CAP : pcnt_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit_want  = (state_ff == kert_pkg::ST_EMIT) && p_vld_ff && e_pend && (ecnt_ff < lim);
   assign emit_stall = emit_want && !out_free;
   assign ecnt_nxt   = ecnt_ff + CW'(emit_want);
   assign emit_end   = !emit_stall && ((ecnt_nxt == lim) || (ptr_ff == N_CNT));
   assign scan_end   = (ptr_ff == N_CNT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kert_pkg::ST_INIT: begin
            if (ptr_ff == CAP) state_in = kert_pkg::ST_IDLE;
         end
         kert_pkg::ST_IDLE: begin
            if (req_valid && enable) state_in = kert_pkg::ST_UPD;
         end
         kert_pkg::ST_UPD: begin
            if (scan_end) state_in = kert_pkg::ST_ORD;
         end
         kert_pkg::ST_ORD: begin
            if (scan_end) state_in = kert_pkg::ST_EMIT;
         end
         kert_pkg::ST_EMIT: begin
            if (emit_end) state_in = kert_pkg::ST_IDLE;
         end
         default: state_in = kert_pkg::ST_INIT;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = (state_ff == kert_pkg::ST_IDLE);
      ptr_in    = ptr_ff;
      p_vld_in  = p_vld_ff;
      p_idx_in  = p_idx_ff;
      wptr_in   = wptr_ff;
      pcnt_in   = pcnt_ff;
      ecnt_in   = ecnt_ff;
      moved_in  = moved_ff;
      rep_in    = rep_ff;
      lev_in    = lev_ff;
      bank_in   = bank_ff;
      rsp_load  = 1'b0;
      pn        = 1'b0;
      a_raddr   = ptr_ff[KW-1:0];
      a_we      = 1'b0;
      a_waddr   = p_idx_ff;
      a_wdata   = new_lvl;
      b_raddr   = {bank_ff, ptr_ff[KW-1:0]};
      b_we      = 1'b0;
      b_waddr   = {~bank_ff, wptr_ff[KW-1:0]};
      b_wdata   = {1'b1, new_lvl, p_idx_ff};

      unique case (state_ff)
         kert_pkg::ST_INIT: begin
            a_we    = 1'b1;
            a_waddr = ptr_ff[KW-1:0];
            a_wdata = kert_pkg::LVL_LOW;
            b_we    = 1'b1;
            b_waddr = {1'b0, ptr_ff[KW-1:0]};
            b_wdata = {1'b0, kert_pkg::LVL_LOW, reset_key(ptr_ff[KW-1:0])};
            bank_in = 1'b0;
            ptr_in  = (ptr_ff == CAP) ? '0 : CW'(ptr_ff + 1'b1);
         end
         kert_pkg::ST_IDLE: begin
            if (req_valid && enable) begin
               rep_in   = rep_scan;
               lev_in   = lev_scan;
               ptr_in   = '0;
               p_vld_in = 1'b0;
               wptr_in  = '0;
               pcnt_in  = '0;
               ecnt_in  = '0;
               moved_in = '0;
            end
         end
         kert_pkg::ST_UPD: begin
            if (scan_end) begin
               ptr_in   = '0;
               p_vld_in = 1'b0;
            end else begin
               ptr_in   = CW'(ptr_ff + 1'b1);
               p_vld_in = 1'b1;
               p_idx_in = ptr_ff[KW-1:0];
            end
            // changed keys go to the front of the new order, in key order
            if (p_vld_ff && rep_ff[p_idx_ff] && (new_lvl != cur_lvl)) begin
               a_we               = 1'b1;
               b_we               = 1'b1;
               wptr_in            = CW'(wptr_ff + 1'b1);
               pcnt_in            = CW'(pcnt_ff + 1'b1);
               moved_in[p_idx_ff] = 1'b1;
            end
         end
         kert_pkg::ST_ORD: begin
            if (scan_end) begin
               ptr_in   = '0;
               p_vld_in = 1'b0;
               bank_in  = ~bank_ff;
            end else begin
               ptr_in   = CW'(ptr_ff + 1'b1);
               p_vld_in = 1'b1;
               p_idx_in = ptr_ff[KW-1:0];
            end
            if (p_vld_ff) begin
               if (HID_ON && (e_key == HID_KEY)) begin
                  b_we    = 1'b1;
                  b_waddr = {~bank_ff, LAST_RANK};
                  b_wdata = {1'b0, e_lvl, e_key};
               end else if (!moved_ff[e_key]) begin
                  // a settled key that was reported loses its pending mark
                  pn      = e_pend && !rep_ff[e_key];
                  b_we    = 1'b1;
                  b_wdata = {pn, e_lvl, e_key};
                  wptr_in = CW'(wptr_ff + 1'b1);
                  pcnt_in = CW'(pcnt_ff + CW'(pn));
               end
            end
         end
         kert_pkg::ST_EMIT: begin
            if (emit_stall) begin
               // hold the read on the entry waiting for the output slot
               b_raddr = {bank_ff, p_idx_ff};
            end else begin
               if (emit_want) begin
                  rsp_load = 1'b1;
                  ecnt_in  = ecnt_nxt;
                  b_we     = 1'b1;
                  b_waddr  = {bank_ff, p_idx_ff};
                  b_wdata  = {1'b0, e_lvl, e_key};
               end
               if (emit_end) begin
                  ptr_in   = '0;
                  p_vld_in = 1'b0;
               end else if (scan_end) begin
                  p_vld_in = 1'b0;
               end else begin
                  ptr_in   = CW'(ptr_ff + 1'b1);
                  p_vld_in = 1'b1;
                  p_idx_in = ptr_ff[KW-1:0];
               end
            end
         end
         default: begin
            ptr_in = '0;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.key_index  = kert_pkg::KEY_W'(e_key);
         rsp_data_in.key_state  = e_lvl;
         rsp_data_in.last_event = (ecnt_nxt == lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kert_pkg::ST_INIT;
         ptr_ff       <= '0;
         p_vld_ff     <= 1'b0;
         wptr_ff      <= '0;
         pcnt_ff      <= '0;
         ecnt_ff      <= '0;
         moved_ff     <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         p_vld_ff     <= p_vld_in;
         wptr_ff      <= wptr_in;
         pcnt_ff      <= pcnt_in;
         ecnt_ff      <= ecnt_in;
         moved_ff     <= moved_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_idx_ff    <= p_idx_in;
      rep_ff      <= rep_in;
      lev_ff      <= lev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kert_pkg::ST_EMIT) |-> (ecnt_ff <= pcnt_ff) && (ecnt_ff <= CAP))
      else $error("emitted count ran past the pending count");

   a_order_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kert_pkg::ST_ORD && scan_end) |-> (wptr_in == FILL_END))
      else $error("new rank order not completely filled");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("output word overwritten while still held");

   a_hidden_fixed: assert property (@(posedge clock) disable iff (reset)
      (moved_ff & HID_MASK) == '0)
      else $error("hidden key was moved");

   a_emit_rw: assert property (@(posedge clock) disable iff (reset)
      (b_we && state_ff == kert_pkg::ST_EMIT) |-> (b_waddr != b_raddr))
      else $error("pending clear collides with the next order read");
`endif

endmodule

### rtl/core/keypad_edge_recency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_edge_recency_tracker
// Each accepted scan word (reported keys plus their levels) moves every
// reported key but the hidden one through low/rise/high/fall, pulls the
// keys that changed to the front of a recency ranking in key order (the
// hidden key stays last), and then returns one rsp word per pending key in
// rank order, last_event marking the final word of the scan; at most
// NUM_KEYS-1 words per scan, any leftover pending key keeps its mark for a
// later scan. Timing: after reset a clearing pass initializes both
// memories, and req_ready stays low until it is done. An enabled scan
// makes one walk over the level memory, one over the rank-order memory to
// rebuild the ranking, and one emission walk that stops at the last pending
// key; each walk moves one entry per cycle through the single write port of
// its memory, the emission walk only while the output register is free. A
// scan taken while enable is low is dropped and the block stays idle. A
// finished rsp word may wait in the output register while the next scan is accepted.
// ----------------------------------------------------------------------------
module keypad_edge_recency_tracker #(
   parameter int NUM_KEYS  = kert_pkg::NUM_KEYS_DEF,
   parameter int FIXED_KEY = kert_pkg::FIXED_KEY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // scan words
   input  logic              req_valid,
   output logic              req_ready,
   input  kert_pkg::req_type req_data,
   // key event words
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kert_pkg::rsp_type rsp_data,
   // enable register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);

   localparam int KW = $clog2(NUM_KEYS);
   localparam int BW = 1 + kert_pkg::LVL_W + KW;   // {pending, level, key}

   logic enable_ff;

   logic [KW-1:0]              a_raddr, a_waddr;
   logic [kert_pkg::LVL_W-1:0] a_rdata, a_wdata;
   logic                       a_we;
   logic [KW:0]                b_raddr, b_waddr;
   logic [BW-1:0]              b_rdata, b_wdata;
   logic                       b_we;

   // enable is to be written only while idle; not enforced here, so always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid) begin
         enable_ff <= csr_wdata;
      end
   end

   // per-key level state
   kert_ram #(
      .WIDTH (kert_pkg::LVL_W),
      .DEPTH (2 ** KW)
   ) u_lvl_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   // rank order, two banks: current order and the one being rebuilt
   kert_ram #(
      .WIDTH (BW),
      .DEPTH (2 ** (KW + 1))
   ) u_ord_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   kert_seq #(
      .NUM_KEYS  (NUM_KEYS),
      .FIXED_KEY (FIXED_KEY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .a_raddr   (a_raddr),
      .a_rdata   (a_rdata),
      .a_we      (a_we),
      .a_waddr   (a_waddr),
      .a_wdata   (a_wdata),
      .b_raddr   (b_raddr),
      .b_rdata   (b_rdata),
      .b_we      (b_we),
      .b_waddr   (b_waddr),
      .b_wdata   (b_wdata)
   );

endmodule

### tb/kert_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kert_event_checker
// Watches the scan, enable and event channels of the keypad tracker, keeps
// its own copy of key levels, pending flags and recency ranking, and checks
// every event word against the oldest predicted one.
// ----------------------------------------------------------------------------
module kert_event_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  kert_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  kert_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_wdata,
   output int                fail_count,
   output int                words_due,
   output int                words_checked
);

   localparam int KEYS     = kert_pkg::NUM_KEYS_DEF;
   localparam int HIDDEN   = kert_pkg::FIXED_KEY_DEF;
   localparam int EMIT_CAP = KEYS - 1;
   localparam int KEY_W    = kert_pkg::KEY_W;

   kert_pkg::lvl_type key_level   [KEYS];
   bit                key_pending [KEYS];
   logic [KEY_W-1:0]  rank_key    [KEYS];
   bit                scans_on;
   kert_pkg::rsp_type event_q [$];
   int                bad_words = 0;
   int                seen_words = 0;

   initial begin
      fail_count    = 0;
      words_due     = 0;
      words_checked = 0;
   end

   function automatic bit is_hidden(input int k);
      return (HIDDEN < KEYS) && (k == HIDDEN);
   endfunction

   task automatic clear_tracker();
      int k;
      int n;
      n = 0;
      for (k = 0; k < KEYS; k++) begin
         key_level[k]   = kert_pkg::LVL_LOW;
         key_pending[k] = 1'b0;
         if (!is_hidden(k)) begin
            rank_key[n] = KEY_W'(k);
            n++;
         end
      end
      if (HIDDEN < KEYS) rank_key[KEYS-1] = KEY_W'(HIDDEN);
      scans_on = 1'b0;
      event_q.delete();
   endtask

   // level step, reranking and emission for one accepted scan
   task automatic predict_scan(input kert_pkg::req_type w);
      logic [KEY_W-1:0]  order [KEYS];
      bit                moved [KEYS];
      kert_pkg::rsp_type ev [$];
      kert_pkg::rsp_type e;
      kert_pkg::lvl_type s;
      logic              was_up;
      logic              now_up;
      logic [KEY_W-1:0]  key;
      int                k;
      int                r;
      int                n;
      if (!scans_on) return;
      n = 0;
      for (k = 0; k < KEYS; k++) moved[k] = 1'b0;
      for (k = 0; k < KEYS; k++) begin
         if (is_hidden(k) || !w.reported_mask[k]) continue;
         now_up = w.level_mask[k];
         s      = key_level[k];
         was_up = (s == kert_pkg::LVL_RISE) || (s == kert_pkg::LVL_HIGH);
         if (was_up == now_up) begin
            if (s == kert_pkg::LVL_RISE) begin
               s = kert_pkg::LVL_HIGH;
            end else if (s == kert_pkg::LVL_FALL) begin
               s = kert_pkg::LVL_LOW;
            end else begin
               // settled key: just drops its pending flag, no move
               key_pending[k] = 1'b0;
               continue;
            end
         end else begin
            s = now_up ? kert_pkg::LVL_RISE : kert_pkg::LVL_FALL;
         end
         key_level[k]   = s;
         key_pending[k] = 1'b1;
         moved[k]       = 1'b1;
         order[n]       = KEY_W'(k);
         n++;
      end
      for (r = 0; r < KEYS; r++) begin
         key = rank_key[r];
         if (is_hidden(key) || moved[key]) continue;
         if (n < KEYS) begin
            order[n] = key;
            n++;
         end
      end
      if (HIDDEN < KEYS) order[KEYS-1] = KEY_W'(HIDDEN);
      for (r = 0; r < KEYS; r++) rank_key[r] = order[r];
      for (r = 0; r < KEYS; r++) begin
         if (ev.size() >= EMIT_CAP) break;
         key = rank_key[r];
         if (!key_pending[key]) continue;
         key_pending[key] = 1'b0;
         e.key_index  = key;
         e.key_state  = key_level[key];
         e.last_event = 1'b0;
         ev = {ev, e};
      end
      for (r = 0; r < ev.size(); r++) begin
         e            = ev[r];
         e.last_event = (r == ev.size() - 1);
         event_q      = {event_q, e};
      end
   endtask

   task automatic check_word(input kert_pkg::rsp_type got);
      kert_pkg::rsp_type want;
      bit                bad;
      seen_words++;
      if (event_q.size() == 0) begin
         $display("%0t: unexpected event word: key %0d state %0d last %0d",
                  $time, got.key_index, got.key_state, got.last_event);
         bad_words++;
         return;
      end
      want = event_q.pop_front();
      bad  = 1'b0;
      if (got.key_index !== want.key_index) begin
         $display("%0t: key_index expected %0d, got %0d",
                  $time, want.key_index, got.key_index);
         bad = 1'b1;
      end
      if (got.key_state !== want.key_state) begin
         $display("%0t: key_state (key %0d) expected %0d, got %0d",
                  $time, want.key_index, want.key_state, got.key_state);
         bad = 1'b1;
      end
      if (got.last_event !== want.last_event) begin
         $display("%0t: last_event (key %0d) expected %0d, got %0d",
                  $time, want.key_index, want.last_event, got.last_event);
         bad = 1'b1;
      end
      if (bad) bad_words++;
   endtask

   // a scan taken at the same edge as an enable write still sees the old bit
   always @(posedge clock) begin
      if (reset) begin
         clear_tracker();
      end else begin
         if (rsp_valid && rsp_ready) check_word(rsp_data);
         if (req_valid && req_ready) predict_scan(req_data);
         if (csr_valid && csr_ready) scans_on = csr_wdata;
      end
      fail_count    <= bad_words;
      words_due     <= event_q.size();
      words_checked <= seen_words;
   end

endmodule

### tb/tb_keypad_edge_recency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_edge_recency_tracker
// Drives keypad scan words into the tracker through bursty traffic while the
// event channel stalls on shifting patterns; the enable bit is flipped
// between phases. A side checker predicts every event word and counts
// mismatches; this top only makes stimulus and calls the verdict.
// ----------------------------------------------------------------------------
module tb_keypad_edge_recency_tracker;

   localparam int MASK_W = kert_pkg::MASK_W;

   // block walks three passes of 25 keys; pad it
   localparam int DRAIN_CYCLES = 3 * kert_pkg::NUM_KEYS_DEF + 40;

   typedef enum int {
      RX_OPEN,
      RX_SPARSE,
      RX_PERIODIC,
      RX_COIN
   } rx_pattern_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kert_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kert_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_wdata = 1'b0;

   int          fail_count;
   int          words_due;
   int          words_checked;

   int          burst_left    = 0;
   int          scans_sent    = 0;
   int          scans_dropped = 0;
   bit          scans_on      = 1'b0;
   // physical key levels; random scans mostly report these
   logic [MASK_W-1:0] held_keys = '0;
   int unsigned    rx_cycle = 0;
   rx_pattern_type rx_mode  = RX_OPEN;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   keypad_edge_recency_tracker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   kert_event_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .words_due     (words_due),
      .words_checked (words_checked)
   );

   // Event-side backpressure. The pattern is redrawn whenever rx_cycle[7:0] is zero:
   // open, mostly-ready random, a fixed 5-of-16 stall, or a coin flip.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[7:0] == 8'd0) rx_mode <= rx_pattern_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_ready <= (rx_cycle[3:0] < 4'd11);
         default:     rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   // One scan word. A burst keeps valid high back to back; a new burst
   // starts after a gap, usually short, now and then long enough to land
   // anywhere in the block's update/reorder/emit walk.
   task automatic send_scan(input logic [MASK_W-1:0] rep,
                            input logic [MASK_W-1:0] lev);
      kert_pkg::req_type w;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                             : $urandom_range(1, 8))
            @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
      end
      w.reported_mask = rep;
      w.level_mask    = lev;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      scans_sent++;
      if (!scans_on) scans_dropped++;
   endtask

   // Random scan. Most are clean reports of the held levels after a few
   // presses/releases, so edges get confirmed and settle; about one in ten
   // is pure noise and some carry a one-key glitch on the level mask.
   task automatic random_scan();
      logic [MASK_W-1:0] rep;
      logic [MASK_W-1:0] lev;
      int                pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         rep = MASK_W'($urandom);
         lev = MASK_W'($urandom);
      end else begin
         repeat ($urandom_range(0, 3)) held_keys[$urandom_range(0, MASK_W-1)] ^= 1'b1;
         if (pick < 7) rep = '1;
         else          rep = MASK_W'($urandom);
         lev = held_keys;
         if (pick == 9) lev[$urandom_range(0, MASK_W-1)] ^= 1'b1;
      end
      send_scan(rep, lev);
   endtask

   // Enable writes only go in with the block idle (see drain below).
   task automatic write_enable(input logic v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scans_on = v;
   endtask

   // Wait until every predicted event word is back, then give the block
   // time to finish a scan that produced no words at all.
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (words_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int ph;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // disabled: these must be dropped without any event
      write_enable(1'b0);
      send_scan('1, '1);
      send_scan('0, '0);
      send_scan(25'h155_5555, 25'h0AA_AAAA);
      drain();

      write_enable(1'b1);
      send_scan('1, '1);                        // every key rises, hidden key stays put
      send_scan('1, '1);                        // rises settle to high
      send_scan('1, '1);                        // all settled: no events
      send_scan('0, '0);                        // empty scan
      send_scan('1, '0);                        // every key falls
      send_scan('0, '1);                        // level with nothing reported
      send_scan('1, '0);                        // falls settle to low
      send_scan(25'd1 << kert_pkg::FIXED_KEY_DEF, '1);  // hidden key alone: ignored
      send_scan(25'h100_0001, 25'h100_0001);    // lowest and highest key rise
      send_scan(25'h100_0000, 25'h100_0000);    // top key settles, moves to front
      send_scan(25'h000_0001, '0);              // key 0 falls back
      send_scan('1, 25'h155_5555);              // alternating levels
      send_scan('1, 25'h0AA_AAAA);              // every key flips
      send_scan('1, 25'h0AA_AAAA);              // and settles
      send_scan(25'h155_5555, '1);              // half report, mixed transitions
      send_scan(25'h0AA_AAAA, '0);
      drain();

      // random phases; the second runs with the block disabled
      held_keys = '0;
      for (ph = 0; ph < 5; ph++) begin
         write_enable(ph != 1);
         repeat ((ph == 1) ? 20 : 60) random_scan();
         drain();
      end

      $display("%0d scans sent (%0d while disabled), %0d event words checked",
               scans_sent, scans_dropped, words_checked);
      $display("enable toggled both ways; directed edges, settles and hidden key covered");
      if (fail_count == 0) begin
         $display("tb_keypad_edge_recency_tracker: clean");
      end else begin
         $display("tb_keypad_edge_recency_tracker: errors");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #12_000_000;
      $display("timeout with %0d event words still due", words_due);
      $display("tb_keypad_edge_recency_tracker: errors");
      $finish;
   end

endmodule
